// ===== rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by every other file of the block.
package rrts_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam logic [15:0] QUANTUM_RESET = 16'd100;

    // Request opcodes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_FORK   = 3'd1;
    localparam logic [2:0] OP_YIELD  = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_EXIT   = 3'd4;

    // Result status codes
    localparam logic [1:0] RES_DONE     = 2'd0;
    localparam logic [1:0] RES_IGNORED  = 2'd1;
    localparam logic [1:0] RES_FULL     = 2'd2;
    localparam logic [1:0] RES_REJECTED = 2'd3;

    // Slot states
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_TERM    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_RD,
        S_ALLOC_CHK,
        S_REQUEUE,
        S_EXIT_RD,
        S_EXIT_CHK,
        S_POP_CHK,
        S_POP_WAIT,
        S_POP_TEST,
        S_SELECT_HIT,
        S_SELECT_IDLE,
        S_FINISH
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic       load;        // capture the accepted transaction
        logic       tick_upd;    // advance or clear the tick counter
        logic       alloc_rd;    // read slot table at allocation pointer
        logic       alloc_take;  // claim the slot at the allocation pointer
        logic       ptr_inc;     // skip the slot at the allocation pointer
        logic       requeue;     // put the running task back in the queue
        logic       exit_rd;     // read slot table at target
        logic       exit_term;   // mark target terminated
        logic       pop_rd;      // pop queue head
        logic       pop_st_rd;   // read slot table at popped entry
        logic       select;      // commit the next running task
        logic       found;       // popped entry is the next task (else idle)
        logic       set_status;
        logic [1:0] status_code;
        logic       out_load;    // load the result register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       run_zero;
        logic       run_user;
        logic       quantum_hit;
        logic       fifo_empty;
        logic       alloc_full;
        logic       tgt_ok;
        logic       tgt_is_run;
        logic [1:0] rd_state;
        logic       out_free;
    } stat_t;

endpackage

// ===== rtl/rrts_ctrl.sv =====
// Sequencing state machine of the round-robin task scheduler.
// Depends on rrts_pkg; drives rrts_dpath through cmd_t and reads stat_t.
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   fork_reject;

    assign fork_reject = stat.run_zero || stat.run_user;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                unique case (stat.opcode)
                    OP_CREATE: state_next = S_ALLOC_RD;
                    OP_FORK:   state_next = fork_reject ? S_FINISH : S_ALLOC_RD;
                    OP_YIELD:  state_next = stat.run_zero ? S_FINISH : S_REQUEUE;
                    OP_TICK:   state_next = (stat.quantum_hit && !stat.fifo_empty) ?
                                            S_REQUEUE : S_FINISH;
                    OP_EXIT:   state_next = stat.tgt_ok ? S_EXIT_RD : S_FINISH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_ALLOC_RD:    state_next = stat.alloc_full ? S_FINISH : S_ALLOC_CHK;
            S_ALLOC_CHK:   state_next = (stat.rd_state == ST_FREE) ? S_FINISH : S_ALLOC_RD;
            S_REQUEUE:     state_next = S_POP_CHK;
            S_EXIT_RD:     state_next = S_EXIT_CHK;
            S_EXIT_CHK:
            begin
                if (stat.rd_state == ST_TERM)
                    state_next = S_FINISH;
                else
                    state_next = stat.tgt_is_run ? S_POP_CHK : S_FINISH;
            end
            S_POP_CHK:     state_next = stat.fifo_empty ? S_SELECT_IDLE : S_POP_WAIT;
            S_POP_WAIT:    state_next = S_POP_TEST;
            S_POP_TEST:    state_next = (stat.rd_state == ST_READY) ? S_SELECT_HIT : S_POP_CHK;
            S_SELECT_HIT:  state_next = S_FINISH;
            S_SELECT_IDLE: state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE:
            begin
                unique case (stat.opcode)
                    OP_FORK:
                    begin
                        if (fork_reject)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = RES_REJECTED;
                        end
                    end
                    OP_YIELD:
                    begin
                        cmd.set_status  = !stat.run_zero;
                        cmd.status_code = RES_DONE;
                    end
                    OP_TICK:
                    begin
                        cmd.tick_upd    = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = RES_DONE;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                    end
                endcase
            end
            S_ALLOC_RD:
            begin
                if (stat.alloc_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = RES_FULL;
                end
                else
                begin
                    cmd.alloc_rd = 1'b1;
                end
            end
            S_ALLOC_CHK:
            begin
                if (stat.rd_state == ST_FREE)
                begin
                    cmd.alloc_take  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = RES_DONE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_REQUEUE:   cmd.requeue = 1'b1;
            S_EXIT_RD:   cmd.exit_rd = 1'b1;
            S_EXIT_CHK:
            begin
                if (stat.rd_state != ST_TERM)
                begin
                    cmd.exit_term   = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = RES_DONE;
                end
            end
            S_POP_CHK:   cmd.pop_rd = !stat.fifo_empty;
            S_POP_WAIT:  cmd.pop_st_rd = 1'b1;
            S_POP_TEST:  cmd.found = 1'b0;
            S_SELECT_HIT:
            begin
                cmd.select = 1'b1;
                cmd.found  = 1'b1;
            end
            S_SELECT_IDLE: cmd.select = 1'b1;
            S_FINISH:    cmd.out_load = stat.out_free;
            default:     cmd.load = 1'b0;
        endcase
    end

endmodule

// ===== rtl/rrts_dpath.sv =====
// Datapath of the round-robin task scheduler: slot table, ready queue,
// tick counter and result register. Depends on rrts_pkg; driven by rrts_ctrl.
module rrts_dpath
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W:0]   NUM_CNT  = (SLOT_W + 1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [31:0]       NS32     = 32'(NUM_SLOTS);

    // Captured request
    logic [2:0] op_reg;
    logic [4:0] tgt_reg;
    logic       usr_reg;

    // Scheduler registers
    logic [15:0]       quantum_reg;
    logic [15:0]       tick_reg;
    logic [SLOT_W-1:0] run_reg;
    logic              run_user_reg;
    logic [SLOT_W:0]   alloc_ptr_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] tail_reg;
    logic [SLOT_W:0]   count_reg;

    // Result being built and result register
    logic [1:0]        res_status_reg;
    logic [SLOT_W-1:0] new_pid_reg;
    logic              sw_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;

    // Slot table: {user, state}; an entry never written reads as its reset value
    logic [2:0]           st_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] st_vld_reg;
    logic [2:0]           st_rd_reg;
    logic                 st_rd_vld_reg;
    logic                 st_rd_zero_reg;
    logic [2:0]           st_rd;

    // Ready queue
    logic [SLOT_W-1:0] fifo_mem [NUM_SLOTS];
    logic [SLOT_W-1:0] fifo_rd_reg;

    logic [SLOT_W-1:0] tgt_idx;
    logic [SLOT_W-1:0] ptr_idx;
    logic [SLOT_W-1:0] next_pid;
    logic              next_user;
    logic              new_user;
    logic [15:0]       tick_inc;
    logic              st_we;
    logic [SLOT_W-1:0] st_waddr;
    logic [2:0]        st_wdata;
    logic              st_re;
    logic [SLOT_W-1:0] st_raddr;
    logic              push;
    logic [SLOT_W-1:0] push_pid;
    logic [SLOT_W:0]   fill_diff;

    assign tgt_idx   = SLOT_W'(tgt_reg);
    assign ptr_idx   = alloc_ptr_reg[SLOT_W-1:0];
    assign tick_inc  = tick_reg + 16'd1;
    assign new_user  = (op_reg == OP_CREATE) ? usr_reg : run_user_reg;
    assign next_pid  = cmd.found ? fifo_rd_reg : '0;
    assign next_user = cmd.found ? st_rd[2] : 1'b0;

    always_comb
    begin
        if (st_rd_vld_reg)
            st_rd = st_rd_reg;
        else
            st_rd = st_rd_zero_reg ? {1'b0, ST_RUNNING} : {1'b0, ST_FREE};
    end

    // Slot table write and read selection
    always_comb
    begin
        st_we    = 1'b1;
        st_waddr = ptr_idx;
        st_wdata = {new_user, ST_READY};
        priority if (cmd.alloc_take)
        begin
            st_waddr = ptr_idx;
            st_wdata = {new_user, ST_READY};
        end
        else if (cmd.requeue && run_reg != '0)
        begin
            st_waddr = run_reg;
            st_wdata = {run_user_reg, ST_READY};
        end
        else if (cmd.exit_term)
        begin
            st_waddr = tgt_idx;
            st_wdata = {st_rd[2], ST_TERM};
        end
        else if (cmd.select)
        begin
            st_waddr = next_pid;
            st_wdata = {next_user, ST_RUNNING};
        end
        else
        begin
            st_we = 1'b0;
        end
    end

    always_comb
    begin
        st_re    = 1'b1;
        st_raddr = ptr_idx;
        priority if (cmd.alloc_rd)
            st_raddr = ptr_idx;
        else if (cmd.exit_rd)
            st_raddr = tgt_idx;
        else if (cmd.pop_st_rd)
            st_raddr = fifo_rd_reg;
        else
            st_re = 1'b0;
    end

    assign push     = (cmd.alloc_take || (cmd.requeue && run_reg != '0)) &&
                      (count_reg < NUM_CNT);
    assign push_pid = cmd.alloc_take ? ptr_idx : run_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        if (st_re)
        begin
            st_rd_reg      <= st_mem[st_raddr];
            st_rd_vld_reg  <= st_vld_reg[st_raddr];
            st_rd_zero_reg <= (st_raddr == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[tail_reg] <= push_pid;
        if (cmd.pop_rd)
            fifo_rd_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg    <= '0;
            quantum_reg   <= QUANTUM_RESET;
            tick_reg      <= '0;
            run_reg       <= '0;
            run_user_reg  <= 1'b0;
            alloc_ptr_reg <= (SLOT_W + 1)'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st_we)
                st_vld_reg[st_waddr] <= 1'b1;
            if (cfg_wr_en)
                quantum_reg <= cfg_wr_data;
            if (cmd.tick_upd)
                tick_reg <= (tick_inc >= quantum_reg) ? 16'd0 : tick_inc;
            if (cmd.select)
            begin
                run_reg      <= next_pid;
                run_user_reg <= next_user;
            end
            if (cmd.alloc_take || cmd.ptr_inc)
                alloc_ptr_reg <= alloc_ptr_reg + (SLOT_W + 1)'(1);
            if (push)
                tail_reg <= (tail_reg == LAST_IDX) ? '0 : tail_reg + SLOT_W'(1);
            if (cmd.pop_rd)
                head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + SLOT_W'(1);
            if (push && !cmd.pop_rd)
                count_reg <= count_reg + (SLOT_W + 1)'(1);
            else if (cmd.pop_rd && !push)
                count_reg <= count_reg - (SLOT_W + 1)'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= s_tdata[2:0];
            tgt_reg        <= s_tdata[7:3];
            usr_reg        <= s_tdata[8];
            res_status_reg <= RES_IGNORED;
            new_pid_reg    <= '0;
            sw_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.set_status)
                res_status_reg <= cmd.status_code;
            if (cmd.alloc_take)
                new_pid_reg <= ptr_idx;
            if (cmd.select)
                sw_reg <= (next_pid != run_reg);
        end
        if (cmd.out_load)
            out_data_reg <= {3'd0, sw_reg, 5'(run_reg), 5'(new_pid_reg), res_status_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        stat.opcode      = op_reg;
        stat.run_zero    = (run_reg == '0);
        stat.run_user    = run_user_reg;
        stat.quantum_hit = (tick_inc >= quantum_reg);
        stat.fifo_empty  = (count_reg == '0);
        stat.alloc_full  = (alloc_ptr_reg == NUM_CNT);
        stat.tgt_ok      = (tgt_reg != 5'd0) && ({27'd0, tgt_reg} < NS32);
        stat.tgt_is_run  = (tgt_idx == run_reg);
        stat.rd_state    = st_rd[1:0];
        stat.out_free    = !out_valid_reg || m_tready;
    end

    assign fill_diff = (tail_reg >= head_reg) ?
                       (SLOT_W + 1)'(tail_reg - head_reg) :
                       (SLOT_W + 1)'(tail_reg) + NUM_CNT - (SLOT_W + 1)'(head_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NUM_CNT)
        else $error("ready queue count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == fill_diff) || (count_reg == NUM_CNT && fill_diff == '0))
        else $error("ready queue pointers disagree with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_ptr_reg != '0 && alloc_ptr_reg <= NUM_CNT)
        else $error("allocation pointer out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result not presented after load");

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// Top level of the round-robin task scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
//
// Hardware round-robin scheduler over NUM_SLOTS task slots. Slot 0 is the
// idle task and runs after reset. Each input transaction is one request
// (create, fork, yield, tick, exit) and yields exactly one result transaction
// carrying the status, the allocated slot, the running slot after the request
// and a switch flag. Slots are handed out lowest never-used first and are
// never reused. Requests are handled one at a time by a sequencer that walks
// a single-port slot table and the ready queue memory, each read registered.
// A tick that does not rotate, a yield by the idle task, a rejected fork
// and any ignored request finish right after decode. Exit of a non-running
// task reads its slot table entry, then marks it terminated. Create or fork
// read the slot table at the allocation pointer, skipping every slot
// terminated before use, or report full once the table is full. A yield
// or a quantum expiry that rotates requeues the running task and pops the
// queue, each popped entry needing a queue read and then a slot table read;
// exit of the running task adds its slot table read. When the queue runs
// dry the idle task is picked. The result waits for a free output register.
// A result waiting in the output register does not block the next request
// from being accepted. The quantum register may be written at any time the
// block is idle; it takes effect on the next tick.
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Requests: [2:0] opcode, [7:3] target_pid, [8] user_context, [15:9] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // Results: [1:0] status, [6:2] new_pid, [11:7] running_pid,
    //          [12] switched, [15:13] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Quantum length in ticks
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: accept a request, step through table and queue accesses,
    // hold the finished result until the output register is free.
    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Slot table, ready queue, tick counter and result register.
    rrts_dpath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
